### hdl/uer_pkg.sv
// shared types, register indexes, reset values and scaling constants
// for the ultrasonic echo ranger; no dependencies
package uer_pkg;

  // counter width default
  localparam int unsigned CountWidthDef = 17;

  // config port layout
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] CfgTriggerWidth   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgResponseTimeout = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgEchoTimeout    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgMinDistance    = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgMaxDistance    = 3'd4;

  // register reset values
  localparam logic [7:0]  TriggerWidthRst    = 8'd15;
  localparam logic [15:0] ResponseTimeoutRst = 16'd5000;
  localparam logic [15:0] EchoTimeoutRst     = 16'd23530;
  localparam logic [8:0]  MinDistanceRst     = 9'd2;
  localparam logic [9:0]  MaxDistanceRst     = 10'd400;

  localparam logic [9:0] LastDistanceRst = 10'd100;
  localparam logic [9:0] ErrDistance     = 10'd999;

  // distance = ticks * 17 / 1000, tracked as running quotient and remainder
  localparam int unsigned DistScale = 17;
  localparam int unsigned DistDiv   = 1000;
  localparam int unsigned RemWidth  = 10;
  // echo high count never passes 65535, so the quotient stays below 1115
  localparam int unsigned QuoWidth  = 11;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_HIGH = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_RESP = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef struct packed {
    logic action;
    logic echo_level;
  } in_item_t;

  typedef struct packed {
    logic       trigger_level;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [9:0] distance;
  } res_item_t;

  typedef struct packed {
    logic [CfgIdxWidth-1:0]  index;
    logic [CfgDataWidth-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0]  trigger_width;
    logic [15:0] response_timeout;
    logic [15:0] echo_timeout;
    logic [8:0]  min_distance;
    logic [9:0]  max_distance;
  } cfg_regs_t;

endpackage

### hdl/uer_if.sv
// valid/ready channel interfaces for the ranger: tick input, result output
// and config write; payload types come from uer_pkg
interface uer_in_if;
  logic             valid;
  logic             ready;
  uer_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface uer_res_if;
  logic               valid;
  logic               ready;
  uer_pkg::res_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface uer_cfg_if;
  logic             valid;
  logic             ready;
  uer_pkg::cfg_wr_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hdl/uer_cfg_regs.sv
// configuration register file of the ranger, written over the config channel
// depends on uer_pkg and uer_cfg_if
module uer_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  uer_cfg_if.sink            cfg_i,
  output uer_pkg::cfg_regs_t regs_o
);

  uer_pkg::cfg_regs_t regs_q, regs_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      // writes to unlisted indexes are dropped
      unique case (cfg_i.payload.index)
        uer_pkg::CfgTriggerWidth:    regs_d.trigger_width    = cfg_i.payload.data[7:0];
        uer_pkg::CfgResponseTimeout: regs_d.response_timeout = cfg_i.payload.data;
        uer_pkg::CfgEchoTimeout:     regs_d.echo_timeout     = cfg_i.payload.data;
        uer_pkg::CfgMinDistance:     regs_d.min_distance     = cfg_i.payload.data[8:0];
        uer_pkg::CfgMaxDistance:     regs_d.max_distance     = cfg_i.payload.data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.trigger_width    <= uer_pkg::TriggerWidthRst;
      regs_q.response_timeout <= uer_pkg::ResponseTimeoutRst;
      regs_q.echo_timeout     <= uer_pkg::EchoTimeoutRst;
      regs_q.min_distance     <= uer_pkg::MinDistanceRst;
      regs_q.max_distance     <= uer_pkg::MaxDistanceRst;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;

endmodule

### hdl/uer_core.sv
// measurement sequencer: phase, tick counter, running distance quotient and
// filtered last distance; depends on uer_pkg
module uer_core #(
  parameter int unsigned COUNT_WIDTH = uer_pkg::CountWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  uer_pkg::in_item_t  item_i,
  input  uer_pkg::cfg_regs_t cfg_i,
  output uer_pkg::res_item_t res_o
);

  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};
  localparam logic [uer_pkg::RemWidth-1:0] RemStep =
    uer_pkg::RemWidth'(uer_pkg::DistScale);
  localparam logic [uer_pkg::RemWidth-1:0] RemWrap =
    uer_pkg::RemWidth'(uer_pkg::DistDiv);

  uer_pkg::phase_e                phase_q, phase_d;
  logic [COUNT_WIDTH-1:0]         cnt_q, cnt_d, cnt_inc;
  logic [uer_pkg::QuoWidth-1:0]   quo_q, quo_d, dist_clamp;
  logic [uer_pkg::RemWidth-1:0]   rem_q, rem_d, rem_sum;
  logic [9:0]                     last_q, last_d, dist_avg;
  logic [10:0]                    avg_sum;
  logic                           trig, done;
  uer_pkg::status_e               status;
  logic [9:0]                     dist_out;

  assign cnt_inc = (cnt_q == CntMax) ? cnt_q : cnt_q + 1'b1;
  assign rem_sum = rem_q + RemStep;

  // clamp low first, then high, then average with the previous distance
  always_comb begin
    dist_clamp = quo_q;
    if (dist_clamp < uer_pkg::QuoWidth'(cfg_i.min_distance)) begin
      dist_clamp = uer_pkg::QuoWidth'(cfg_i.min_distance);
    end
    if (dist_clamp > uer_pkg::QuoWidth'(cfg_i.max_distance)) begin
      dist_clamp = uer_pkg::QuoWidth'(cfg_i.max_distance);
    end
  end

  assign avg_sum  = dist_clamp + 11'(last_q);
  assign dist_avg = avg_sum[10:1];

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    last_d   = last_q;
    trig     = 1'b0;
    done     = 1'b0;
    status   = uer_pkg::ST_OK;
    dist_out = '0;
    unique case (phase_q)
      uer_pkg::PH_IDLE: begin
        if (item_i.action) begin
          trig = 1'b1;
          if (cfg_i.trigger_width <= 8'd1) begin
            phase_d = uer_pkg::PH_WAIT;
            cnt_d   = '0;
          end else begin
            phase_d = uer_pkg::PH_TRIG;
            cnt_d   = COUNT_WIDTH'(1);
          end
        end
      end
      uer_pkg::PH_TRIG: begin
        trig  = 1'b1;
        cnt_d = cnt_inc;
        if (cnt_inc >= COUNT_WIDTH'(cfg_i.trigger_width)) begin
          phase_d = uer_pkg::PH_WAIT;
          cnt_d   = '0;
        end
      end
      uer_pkg::PH_WAIT: begin
        if (!item_i.echo_level) begin
          cnt_d = cnt_inc;
          if (cnt_inc > COUNT_WIDTH'(cfg_i.response_timeout)) begin
            done     = 1'b1;
            status   = uer_pkg::ST_NO_RESP;
            dist_out = uer_pkg::ErrDistance;
            phase_d  = uer_pkg::PH_IDLE;
            cnt_d    = '0;
          end
        end else begin
          // first high sample is high tick one
          phase_d = uer_pkg::PH_HIGH;
          cnt_d   = COUNT_WIDTH'(1);
          quo_d   = '0;
          rem_d   = RemStep;
          if (cfg_i.echo_timeout == 16'd0) begin
            done     = 1'b1;
            status   = uer_pkg::ST_RANGE;
            dist_out = uer_pkg::ErrDistance;
            last_d   = cfg_i.max_distance;
            phase_d  = uer_pkg::PH_IDLE;
            cnt_d    = '0;
          end
        end
      end
      uer_pkg::PH_HIGH: begin
        if (item_i.echo_level) begin
          cnt_d = cnt_inc;
          if (cnt_q != CntMax) begin
            if (rem_sum >= RemWrap) begin
              rem_d = rem_sum - RemWrap;
              quo_d = quo_q + 1'b1;
            end else begin
              rem_d = rem_sum;
            end
          end
          if (cnt_inc > COUNT_WIDTH'(cfg_i.echo_timeout)) begin
            done     = 1'b1;
            status   = uer_pkg::ST_RANGE;
            dist_out = uer_pkg::ErrDistance;
            last_d   = cfg_i.max_distance;
            phase_d  = uer_pkg::PH_IDLE;
            cnt_d    = '0;
          end
        end else begin
          done     = 1'b1;
          status   = uer_pkg::ST_OK;
          dist_out = dist_avg;
          last_d   = dist_avg;
          phase_d  = uer_pkg::PH_IDLE;
          cnt_d    = '0;
        end
      end
      default: begin
        phase_d = uer_pkg::PH_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uer_pkg::PH_IDLE;
      cnt_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      last_q  <= uer_pkg::LastDistanceRst;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      quo_q   <= quo_d;
      rem_q   <= rem_d;
      last_q  <= last_d;
    end
  end

  assign res_o.trigger_level = trig;
  assign res_o.busy_res      = (phase_d != uer_pkg::PH_IDLE);
  assign res_o.done_res      = done;
  assign res_o.status        = status;
  assign res_o.distance      = dist_out;

endmodule

### hdl/ultrasonic_echo_ranger_unit.sv
// Ultrasonic echo-pulse ranger. Every input transfer is one microsecond tick
// carrying the sampled echo level and a start request, and gives exactly one
// result transfer with the trigger level, busy, done, status and distance.
// A tick is registered on input, evaluated against the sequencer state
// combinationally and held in an output register, so one tick is taken per
// clock; the output register stalls the input side only when a result is
// not taken. The distance is kept as a running quotient of
// ticks*17/1000, updated on every echo-high tick, so no divider is needed.
// Config writes are taken at any time but are meant for idle periods only.
// Depends on uer_pkg, uer_if, uer_cfg_regs and uer_core.
module ultrasonic_echo_ranger_unit #(
  parameter int unsigned COUNT_WIDTH = uer_pkg::CountWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  uer_in_if.sink    in_i,
  uer_res_if.source res_o,
  uer_cfg_if.sink   cfg_i
);

  uer_pkg::cfg_regs_t regs;
  uer_pkg::res_item_t res_d;

  logic               in_vld_q;
  uer_pkg::in_item_t  in_item_q;
  logic               out_vld_q;
  uer_pkg::res_item_t out_item_q;
  logic               advance, step;

  uer_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  // result register free or being emptied this cycle
  assign advance     = !out_vld_q || res_o.ready;
  assign step        = in_vld_q && advance;
  assign in_i.ready  = !in_vld_q || advance;

  uer_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (regs),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_i.payload;
    end
    if (step) begin
      out_item_q <= res_d;
    end
  end

  assign res_o.valid   = out_vld_q;
  assign res_o.payload = out_item_q;

endmodule
